// ===== design/ttm_pkg.sv =====
// Shared types, command codes and event codes of the thermal trip monitor.
package ttm_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_ZONE_WR = 2'd0;
  localparam logic [1:0] CMD_TRIP_WR = 2'd1;
  localparam logic [1:0] CMD_READING = 2'd2;

  // Trip kinds.
  localparam logic [1:0] KIND_PASSIVE  = 2'd0;
  localparam logic [1:0] KIND_HOT      = 2'd1;
  localparam logic [1:0] KIND_CRITICAL = 2'd2;
  localparam logic [1:0] KIND_OTHER    = 2'd3;

  // Event kinds.
  localparam logic [2:0] EV_THROTTLE_ON  = 3'd0;
  localparam logic [2:0] EV_HOT          = 3'd1;
  localparam logic [2:0] EV_CRITICAL     = 3'd2;
  localparam logic [2:0] EV_CROSSED      = 3'd3;
  localparam logic [2:0] EV_THROTTLE_OFF = 3'd4;
  localparam logic [2:0] EV_COOL         = 3'd5;
  localparam logic [2:0] EV_CLEARED      = 3'd6;

  // Reading value that means no sensor data.
  localparam logic signed [15:0] NO_READING = 16'sh8000;

  // At most this many events are reported for one reading.
  localparam int unsigned MAX_EVENTS = 8;
  localparam int unsigned EVCNT_W    = 4;

  // Operation of a queued job.
  typedef enum logic [1:0] {
    OP_ZONE = 2'd0,
    OP_TRIP = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // One input item.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         zone_index;
    logic [2:0]         trip_index;
    logic signed [15:0] temperature;
    logic signed [15:0] threshold;
    logic [14:0]        hysteresis;
    logic [1:0]         trip_kind;
    logic [7:0]         zone_tag;
    logic               zone_enable;
    logic [3:0]         trip_count;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [2:0]         event_kind;
    logic [7:0]         event_zone;
    logic signed [15:0] event_temperature;
    logic signed [15:0] event_threshold;
    logic               throttled_now;
    logic               emergency_now;
    logic [31:0]        throttle_total;
    logic [31:0]        emergency_total;
    logic               last_event;
  } out_t;

  // Classified job passed from the front end to the back end.
  typedef struct packed {
    op_e                op;
    logic [2:0]         zone_index;
    logic [2:0]         trip_index;
    logic signed [15:0] temperature;
    logic signed [15:0] threshold;
    logic [14:0]        hysteresis;
    logic [1:0]         trip_kind;
    logic [7:0]         zone_tag;
    logic               zone_enable;
    logic [3:0]         trip_count;
  } job_t;

  // One stored trip entry.
  typedef struct packed {
    logic signed [15:0] threshold;
    logic [14:0]        hysteresis;
    logic [1:0]         kind;
  } trip_t;

endpackage

// ===== design/thermal_trip_monitor_core.sv =====
// Top level of the thermal trip monitor: front end, job queue and back end.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   in_data_i  (ttm_pkg::in_t)
//   output   out        out_valid_o / out_stall_i out_data_o (ttm_pkg::out_t)
//
// A zone or trip write is applied while idle; a reading of a zone with N trips
// starts the walk, evaluates each trip in turn and ends with the final flush; the single
// read port of the trip memory is walked one entry per cycle unless the walk stalls.
// A two-entry queue lets the front end keep accepting while the back end works.
// Reset clears all tables, flags and counters at once; there is no clearing pass.
// A stalled output holds the walk only when a new event finds the pending slot full.
module thermal_trip_monitor_core #(
  parameter int unsigned ZONES = 8,
  parameter int unsigned TRIPS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ttm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ttm_pkg::out_t out_data_o
);

  logic          q_full, q_push, q_valid, q_pop;
  ttm_pkg::job_t push_job, head_job;

  // Classify incoming transfers.
  ttm_front #(
    .ZONES(ZONES),
    .TRIPS(TRIPS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .job_o     (push_job)
  );

  // Decoupling queue.
  ttm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .full_o (q_full),
    .valid_o(q_valid),
    .job_o  (head_job),
    .pop_i  (q_pop)
  );

  // Execute jobs and report events.
  ttm_back #(
    .ZONES(ZONES),
    .TRIPS(TRIPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== design/ttm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ttm_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ttm_front.sv =====
// Front end: accepts input items, drops ignored ones and classifies the rest.
module ttm_front #(
  parameter int unsigned ZONES = 8,
  parameter int unsigned TRIPS = 8
) (
  input  logic          in_valid_i,
  input  ttm_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  input  logic          q_full_i,
  output logic          push_o,
  output ttm_pkg::job_t job_o
);

  logic keep;

  // Decide whether the item has any effect and map its command to a job.
  always_comb begin
    keep              = 1'b0;
    job_o.op          = ttm_pkg::OP_ZONE;
    job_o.zone_index  = in_data_i.zone_index;
    job_o.trip_index  = in_data_i.trip_index;
    job_o.temperature = in_data_i.temperature;
    job_o.threshold   = in_data_i.threshold;
    job_o.hysteresis  = in_data_i.hysteresis;
    job_o.trip_kind   = in_data_i.trip_kind;
    job_o.zone_tag    = in_data_i.zone_tag;
    job_o.zone_enable = in_data_i.zone_enable;
    job_o.trip_count  = in_data_i.trip_count;
    if (32'(in_data_i.trip_count) > TRIPS) begin
      job_o.trip_count = 4'(TRIPS);
    end
    case (in_data_i.cmd)
      ttm_pkg::CMD_ZONE_WR: begin
        job_o.op = ttm_pkg::OP_ZONE;
        keep     = 1'b1;
      end
      ttm_pkg::CMD_TRIP_WR: begin
        job_o.op = ttm_pkg::OP_TRIP;
        keep     = 32'(in_data_i.trip_index) < TRIPS;
      end
      ttm_pkg::CMD_READING: begin
        job_o.op = ttm_pkg::OP_READ;
        keep     = in_data_i.temperature != ttm_pkg::NO_READING;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    if (32'(in_data_i.zone_index) >= ZONES) begin
      keep = 1'b0;
    end
  end

  // Every transfer is taken while the queue has room; dropped items push nothing.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

// ===== design/ttm_queue.sv =====
// Two-entry job queue between the front end and the back end.
module ttm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttm_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  output ttm_pkg::job_t job_o,
  input  logic          pop_i
);

  ttm_pkg::job_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign job_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== design/ttm_back.sv =====
// Back end: owns the zone and trip tables, executes jobs and walks trips.
module ttm_back #(
  parameter int unsigned ZONES = 8,
  parameter int unsigned TRIPS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ttm_pkg::job_t q_job_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ttm_pkg::out_t out_data_o
);

  localparam int unsigned DEPTH = ZONES * TRIPS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned ZW    = ZONES > 1 ? $clog2(ZONES) : 1;
  localparam int unsigned CW    = $clog2(TRIPS + 1);
  localparam int unsigned TW    = $bits(ttm_pkg::trip_t);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Control and table state.
  logic [1:0]                   state_q, state_d;
  logic [7:0]                   zone_tag_q [ZONES];
  logic [ZONES-1:0]             zone_en_q;
  logic [CW-1:0]                zone_cnt_q [ZONES];
  logic [DEPTH-1:0]             trip_vld_q;
  logic [DEPTH-1:0]             trip_act_q;
  logic                         rd_vld_q;
  logic                         throttle_q, throttle_d;
  logic                         emerg_q, emerg_d;
  logic [31:0]                  thr_cnt_q, thr_cnt_d;
  logic [31:0]                  emg_cnt_q, emg_cnt_d;
  logic [AW-1:0]                addr_q;
  logic [CW-1:0]                idx_q;
  logic [CW-1:0]                cnt_q;
  logic [ttm_pkg::EVCNT_W-1:0]  ev_cnt_q;
  logic                         pend_vld_q, pend_vld_d;
  ttm_pkg::out_t                pend_q;
  logic                         out_vld_q, out_vld_d;
  ttm_pkg::out_t                out_q, out_d;
  logic signed [15:0]           temp_q;
  logic [7:0]                   tag_q;

  // Combinational signals.
  logic [ZW-1:0]      zsel;
  logic               idle_job, start_read, zone_wr, trip_wr;
  logic [AW-1:0]      base_addr, wr_addr, rd_addr;
  logic               ram_re;
  logic [TW-1:0]      ram_rdata;
  ttm_pkg::trip_t     trip_wdata, trip;
  logic               active, ge_hit, lt_hit, set_hit, clr_hit, hit, report;
  logic signed [17:0] clr_limit, temp_ext;
  logic               can_push, walk_stall, walk_adv, walk_last;
  logic               push_walk, push_flush;
  logic [2:0]         ev_kind;
  ttm_pkg::out_t      ev;

  // Job decode while idle.
  assign zsel       = ZW'(q_job_i.zone_index);
  assign idle_job   = state_q == ST_IDLE && q_valid_i;
  assign zone_wr    = idle_job && q_job_i.op == ttm_pkg::OP_ZONE;
  assign trip_wr    = idle_job && q_job_i.op == ttm_pkg::OP_TRIP;
  assign start_read = idle_job && q_job_i.op == ttm_pkg::OP_READ && zone_en_q[zsel]
                      && zone_cnt_q[zsel] != '0;
  assign q_pop_o    = idle_job;
  assign base_addr  = AW'(int'(q_job_i.zone_index) * TRIPS);
  assign wr_addr    = AW'(int'(q_job_i.zone_index) * TRIPS + int'(q_job_i.trip_index));

  assign trip_wdata.threshold  = q_job_i.threshold;
  assign trip_wdata.hysteresis = q_job_i.hysteresis;
  assign trip_wdata.kind       = q_job_i.trip_kind;

  // Trip entry memory; the walk reads one entry ahead of evaluation.
  assign rd_addr = start_read ? base_addr : addr_q + AW'(1);
  assign ram_re  = start_read || (walk_adv && !walk_last);

  ttm_ram #(
    .WIDTH(TW),
    .DEPTH(DEPTH)
  ) u_trip_ram (
    .clk_i  (clk_i),
    .we_i   (trip_wr),
    .waddr_i(wr_addr),
    .wdata_i(trip_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Evaluate the current trip; an entry never written reads as zero.
  always_comb begin
    trip      = rd_vld_q ? ttm_pkg::trip_t'(ram_rdata) : '0;
    active    = trip_act_q[addr_q];
    ge_hit    = temp_q >= trip.threshold;
    temp_ext  = 18'(temp_q);
    clr_limit = 18'(trip.threshold) - $signed({3'b000, trip.hysteresis});
    lt_hit    = temp_ext < clr_limit;
    set_hit   = !active && ge_hit;
    clr_hit   = active && lt_hit;
    hit       = set_hit || clr_hit;
    report    = 32'(ev_cnt_q) < ttm_pkg::MAX_EVENTS;
  end

  // Event kind and the flags and counters after this event.
  always_comb begin
    throttle_d = throttle_q;
    emerg_d    = emerg_q;
    thr_cnt_d  = thr_cnt_q;
    emg_cnt_d  = emg_cnt_q;
    ev_kind    = ttm_pkg::EV_CLEARED;
    if (set_hit) begin
      case (trip.kind)
        ttm_pkg::KIND_PASSIVE: begin
          ev_kind    = ttm_pkg::EV_THROTTLE_ON;
          throttle_d = 1'b1;
          thr_cnt_d  = thr_cnt_q + 32'd1;
        end
        ttm_pkg::KIND_HOT: begin
          ev_kind = ttm_pkg::EV_HOT;
        end
        ttm_pkg::KIND_CRITICAL: begin
          ev_kind   = ttm_pkg::EV_CRITICAL;
          emerg_d   = 1'b1;
          emg_cnt_d = emg_cnt_q + 32'd1;
        end
        default: begin
          ev_kind = ttm_pkg::EV_CROSSED;
        end
      endcase
    end else begin
      case (trip.kind)
        ttm_pkg::KIND_PASSIVE: begin
          ev_kind    = ttm_pkg::EV_THROTTLE_OFF;
          throttle_d = 1'b0;
        end
        ttm_pkg::KIND_HOT: begin
          ev_kind = ttm_pkg::EV_COOL;
        end
        default: begin
          ev_kind = ttm_pkg::EV_CLEARED;
        end
      endcase
    end
    ev.event_kind        = ev_kind;
    ev.event_zone        = tag_q;
    ev.event_temperature = temp_q;
    ev.event_threshold   = trip.threshold;
    ev.throttled_now     = throttle_d;
    ev.emergency_now     = emerg_d;
    ev.throttle_total    = thr_cnt_d;
    ev.emergency_total   = emg_cnt_d;
    ev.last_event        = 1'b0;
  end

  // The newest event waits in a pending slot until it is known whether it is the last.
  assign can_push   = !out_vld_q || !out_stall_i;
  assign walk_stall = hit && report && pend_vld_q && !can_push;
  assign walk_adv   = state_q == ST_WALK && !walk_stall;
  assign walk_last  = idx_q == cnt_q - CW'(1);
  assign push_walk  = walk_adv && hit && report && pend_vld_q;
  assign push_flush = state_q == ST_FLUSH && pend_vld_q && can_push;

  // Output register and pending slot.
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    pend_vld_d = pend_vld_q;
    if (push_walk || push_flush) begin
      out_vld_d        = 1'b1;
      out_d            = pend_q;
      out_d.last_event = push_flush;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (walk_adv && hit && report) begin
      pend_vld_d = 1'b1;
    end else if (push_flush) begin
      pend_vld_d = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_read) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_adv && walk_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q || can_push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control, tables, flags and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      zone_en_q  <= '0;
      trip_vld_q <= '0;
      trip_act_q <= '0;
      rd_vld_q   <= 1'b0;
      throttle_q <= 1'b0;
      emerg_q    <= 1'b0;
      thr_cnt_q  <= '0;
      emg_cnt_q  <= '0;
      addr_q     <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      ev_cnt_q   <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int z = 0; z < ZONES; z++) begin
        zone_tag_q[z] <= '0;
        zone_cnt_q[z] <= '0;
      end
    end else begin
      state_q    <= state_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
      if (zone_wr) begin
        zone_tag_q[zsel] <= q_job_i.zone_tag;
        zone_en_q[zsel]  <= q_job_i.zone_enable;
        zone_cnt_q[zsel] <= CW'(q_job_i.trip_count);
      end
      if (trip_wr) begin
        trip_vld_q[wr_addr] <= 1'b1;
        trip_act_q[wr_addr] <= 1'b0;
      end
      if (start_read) begin
        addr_q   <= base_addr;
        rd_vld_q <= trip_vld_q[base_addr];
        idx_q    <= '0;
        cnt_q    <= zone_cnt_q[zsel];
        ev_cnt_q <= '0;
      end
      if (walk_adv) begin
        if (hit) begin
          trip_act_q[addr_q] <= set_hit;
          throttle_q         <= throttle_d;
          emerg_q            <= emerg_d;
          thr_cnt_q          <= thr_cnt_d;
          emg_cnt_q          <= emg_cnt_d;
          if (report) begin
            ev_cnt_q <= ev_cnt_q + ttm_pkg::EVCNT_W'(1);
          end
        end
        if (!walk_last) begin
          addr_q   <= addr_q + AW'(1);
          rd_vld_q <= trip_vld_q[addr_q + AW'(1)];
          idx_q    <= idx_q + CW'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (walk_adv && hit && report) begin
      pend_q <= ev;
    end
    if (start_read) begin
      temp_q <= q_job_i.temperature;
      tag_q  <= zone_tag_q[zsel];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the thermal trip monitor core.
module tb;

  // Command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int ZONES         = 8;
  localparam int TRIPS         = 8;
  localparam int RANDOM_ITEMS  = 216;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 40;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  ttm_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  ttm_pkg::out_t out_data_o;

  thermal_trip_monitor_core #(
    .ZONES(ZONES),
    .TRIPS(TRIPS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // One directed row: the item and, where it is obvious, the event it must give.
  // A negative want_count means the row is checked against the trip model.
  typedef struct {
    ttm_pkg::in_t  item;
    int            want_count;
    ttm_pkg::out_t want;
  } row_t;

  // Shadow copy of the trip and zone tables, flags and counters.
  logic signed [15:0] trip_thr_mem  [ZONES*TRIPS];
  logic [14:0]        trip_hys_mem  [ZONES*TRIPS];
  logic [1:0]         trip_kind_mem [ZONES*TRIPS];
  logic               trip_act_mem  [ZONES*TRIPS];
  logic [7:0]         zone_tag_mem  [ZONES];
  logic               zone_en_mem   [ZONES];
  logic [3:0]         zone_cnt_mem  [ZONES];
  logic               throttle_on;
  logic               emergency_on;
  logic [31:0]        throttle_cnt;
  logic [31:0]        emergency_cnt;

  ttm_pkg::out_t new_events[$];
  ttm_pkg::out_t expected_events[$];

  int errors;
  int items_sent;
  int events_seen;
  int cycles;
  int in_idle_pct;
  int out_stall_pct;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still expected", cycles,
               expected_events.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver backpressure.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Prints one mismatch line and counts it; printing stops after PRINT_LIMIT mismatches.
  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("event %0d %s: got %h, expected %h", events_seen, name,
                              got, want));
  endtask

  // Records one event with the flags and counters as they stand now.
  function automatic void push_event(input logic [2:0] kind, input int zone, input int idx,
                                     input logic signed [15:0] temp);
    ttm_pkg::out_t ev;
    if (new_events.size() >= ttm_pkg::MAX_EVENTS) return;
    ev.event_kind        = kind;
    ev.event_zone        = zone_tag_mem[zone];
    ev.event_temperature = temp;
    ev.event_threshold   = trip_thr_mem[idx];
    ev.throttled_now     = throttle_on;
    ev.emergency_now     = emergency_on;
    ev.throttle_total    = throttle_cnt;
    ev.emergency_total   = emergency_cnt;
    ev.last_event        = 1'b0;
    new_events.push_back(ev);
  endfunction

  // Applies one item to the shadow tables and collects the trip crossings it causes.
  function automatic void walk_trips(input ttm_pkg::in_t it);
    int z;
    int idx;
    int temp;
    int lim;
    int margin;
    new_events.delete();
    z = it.zone_index;
    case (it.cmd)
      ttm_pkg::CMD_ZONE_WR: begin
        zone_tag_mem[z] = it.zone_tag;
        zone_en_mem[z]  = it.zone_enable;
        zone_cnt_mem[z] = (it.trip_count > TRIPS) ? 4'(TRIPS) : it.trip_count;
      end
      ttm_pkg::CMD_TRIP_WR: begin
        idx = z * TRIPS + it.trip_index;
        trip_thr_mem[idx]  = it.threshold;
        trip_hys_mem[idx]  = it.hysteresis;
        trip_kind_mem[idx] = it.trip_kind;
        trip_act_mem[idx]  = 1'b0;
      end
      ttm_pkg::CMD_READING: begin
        if (!zone_en_mem[z] || it.temperature == ttm_pkg::NO_READING) return;
        temp = it.temperature;
        for (int i = 0; i < zone_cnt_mem[z]; i++) begin
          idx    = z * TRIPS + i;
          lim    = trip_thr_mem[idx];
          margin = trip_hys_mem[idx];
          if (!trip_act_mem[idx] && temp >= lim) begin
            // Trip sets.
            trip_act_mem[idx] = 1'b1;
            case (trip_kind_mem[idx])
              ttm_pkg::KIND_PASSIVE: begin
                throttle_on  = 1'b1;
                throttle_cnt = throttle_cnt + 1;
                push_event(ttm_pkg::EV_THROTTLE_ON, z, idx, it.temperature);
              end
              ttm_pkg::KIND_HOT: push_event(ttm_pkg::EV_HOT, z, idx, it.temperature);
              ttm_pkg::KIND_CRITICAL: begin
                emergency_on  = 1'b1;
                emergency_cnt = emergency_cnt + 1;
                push_event(ttm_pkg::EV_CRITICAL, z, idx, it.temperature);
              end
              default: push_event(ttm_pkg::EV_CROSSED, z, idx, it.temperature);
            endcase
          end else if (trip_act_mem[idx] && temp < lim - margin) begin
            // Trip clears; the emergency flag stays set.
            trip_act_mem[idx] = 1'b0;
            case (trip_kind_mem[idx])
              ttm_pkg::KIND_PASSIVE: begin
                throttle_on = 1'b0;
                push_event(ttm_pkg::EV_THROTTLE_OFF, z, idx, it.temperature);
              end
              ttm_pkg::KIND_HOT: push_event(ttm_pkg::EV_COOL, z, idx, it.temperature);
              default:  push_event(ttm_pkg::EV_CLEARED, z, idx, it.temperature);
            endcase
          end
        end
        if (new_events.size() > 0) new_events[new_events.size()-1].last_event = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Item with every field random; the helpers below overwrite what matters.
  function automatic ttm_pkg::in_t noise_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return ttm_pkg::in_t'(bits[$bits(ttm_pkg::in_t)-1:0]);
  endfunction

  function automatic ttm_pkg::in_t zone_wr(input logic [2:0] z, input logic [7:0] tag,
                                           input logic en, input logic [3:0] cnt);
    ttm_pkg::in_t it;
    it             = noise_item();
    it.cmd         = ttm_pkg::CMD_ZONE_WR;
    it.zone_index  = z;
    it.zone_tag    = tag;
    it.zone_enable = en;
    it.trip_count  = cnt;
    return it;
  endfunction

  function automatic ttm_pkg::in_t trip_wr(input logic [2:0] z, input logic [2:0] t,
                                           input logic signed [15:0] thr,
                                           input logic [14:0] hys,
                                           input logic [1:0] kind);
    ttm_pkg::in_t it;
    it            = noise_item();
    it.cmd        = ttm_pkg::CMD_TRIP_WR;
    it.zone_index = z;
    it.trip_index = t;
    it.threshold  = thr;
    it.hysteresis = hys;
    it.trip_kind  = kind;
    return it;
  endfunction

  function automatic ttm_pkg::in_t reading(input logic [2:0] z,
                                           input logic signed [15:0] temp);
    ttm_pkg::in_t it;
    it             = noise_item();
    it.cmd         = ttm_pkg::CMD_READING;
    it.zone_index  = z;
    it.temperature = temp;
    return it;
  endfunction

  function automatic ttm_pkg::out_t single_event(input logic [2:0] kind,
                                                 input logic [7:0] tag,
                                                 input logic signed [15:0] temp,
                                                 input logic signed [15:0] thr,
                                                 input logic thr_now, input logic em_now,
                                                 input logic [31:0] t_total,
                                                 input logic [31:0] e_total);
    ttm_pkg::out_t ev;
    ev.event_kind        = kind;
    ev.event_zone        = tag;
    ev.event_temperature = temp;
    ev.event_threshold   = thr;
    ev.throttled_now     = thr_now;
    ev.emergency_now     = em_now;
    ev.throttle_total    = t_total;
    ev.emergency_total   = e_total;
    ev.last_event        = 1'b1;
    return ev;
  endfunction

  // Presents one item, waits for its transfer and records what it should produce.
  task automatic send_item(input ttm_pkg::in_t it, input int want_count,
                           input ttm_pkg::out_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
    walk_trips(it);
    if (want_count < 0) begin
      foreach (new_events[k]) expected_events.push_back(new_events[k]);
    end else if (want_count > 0) begin
      expected_events.push_back(want);
    end
  endtask

  // Output checker: every event transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_events
    ttm_pkg::out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        flag_mismatch($sformatf("event %0d arrived with nothing expected (kind %0d)",
                                events_seen, out_data_o.event_kind));
      end else begin
        want = expected_events.pop_front();
        check_field("kind", 32'(out_data_o.event_kind), 32'(want.event_kind));
        check_field("zone", 32'(out_data_o.event_zone), 32'(want.event_zone));
        check_field("temperature", 32'(out_data_o.event_temperature[15:0]),
                    32'(want.event_temperature[15:0]));
        check_field("threshold", 32'(out_data_o.event_threshold[15:0]),
                    32'(want.event_threshold[15:0]));
        check_field("throttled", 32'(out_data_o.throttled_now), 32'(want.throttled_now));
        check_field("emergency", 32'(out_data_o.emergency_now), 32'(want.emergency_now));
        check_field("throttle_total", out_data_o.throttle_total, want.throttle_total);
        check_field("emergency_total", out_data_o.emergency_total, want.emergency_total);
        check_field("last", 32'(out_data_o.last_event), 32'(want.last_event));
      end
    end
  end

  // Stimulus: directed table, then random items in three flow-control phases.
  initial begin : stimulus
    row_t         rows[$];
    ttm_pkg::in_t it;
    int           pick;
    int           tv;
    int           useful;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    in_idle_pct   = 16;
    out_stall_pct = 64;
    foreach (trip_thr_mem[i]) begin
      trip_thr_mem[i]  = '0;
      trip_hys_mem[i]  = '0;
      trip_kind_mem[i] = '0;
      trip_act_mem[i]  = 1'b0;
    end
    foreach (zone_tag_mem[i]) begin
      zone_tag_mem[i] = '0;
      zone_en_mem[i]  = 1'b0;
      zone_cnt_mem[i] = '0;
    end
    throttle_on   = 1'b0;
    emergency_on  = 1'b0;
    throttle_cnt  = '0;
    emergency_cnt = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every zone is disabled after reset.
    rows.push_back('{reading(3'd0, 16'sd100), 0, '0});
    // Single passive trip at the top of the range with no hysteresis.
    rows.push_back('{zone_wr(3'd0, 8'hA5, 1'b1, 4'd1), 0, '0});
    rows.push_back('{trip_wr(3'd0, 3'd0, 16'sh7FFF, 15'd0, ttm_pkg::KIND_PASSIVE), 0, '0});
    rows.push_back('{reading(3'd0, 16'sh7FFE), 0, '0});
    rows.push_back('{reading(3'd0, ttm_pkg::NO_READING), 0, '0});
    rows.push_back('{reading(3'd0, 16'sh7FFF), 1,
                     single_event(ttm_pkg::EV_THROTTLE_ON, 8'hA5, 16'sh7FFF, 16'sh7FFF,
                                  1'b1, 1'b0, 32'd1, 32'd0)});
    rows.push_back('{reading(3'd0, 16'sh7FFE), 1,
                     single_event(ttm_pkg::EV_THROTTLE_OFF, 8'hA5, 16'sh7FFE, 16'sh7FFF,
                                  1'b0, 1'b0, 32'd1, 32'd0)});
    // Critical trip at the bottom with the widest hysteresis: it can never clear.
    rows.push_back('{trip_wr(3'd0, 3'd0, 16'sh8000, 15'h7FFF, ttm_pkg::KIND_CRITICAL),
                     0, '0});
    rows.push_back('{reading(3'd0, 16'sh8001), 1,
                     single_event(ttm_pkg::EV_CRITICAL, 8'hA5, 16'sh8001, 16'sh8000,
                                  1'b0, 1'b1, 32'd1, 32'd1)});
    rows.push_back('{reading(3'd0, 16'sh8001), 0, '0});
    it = reading(3'd0, 16'sd0);
    it.cmd = CMD_UNUSED;
    rows.push_back('{it, 0, '0});
    // Oversized trip count saturates; the walk covers every trip of the zone.
    rows.push_back('{zone_wr(3'd1, 8'hFF, 1'b1, 4'd15), 0, '0});
    rows.push_back('{trip_wr(3'd1, 3'd0, 16'sd100, 15'd50, ttm_pkg::KIND_HOT), 0, '0});
    rows.push_back('{trip_wr(3'd1, 3'd1, 16'sd200, 15'h7FFF, ttm_pkg::KIND_OTHER), 0, '0});
    rows.push_back('{trip_wr(3'd1, 3'd7, -16'sd50, 15'd0, ttm_pkg::KIND_PASSIVE), 0, '0});
    rows.push_back('{reading(3'd1, 16'sd250), -1, '0});
    rows.push_back('{reading(3'd1, 16'sd60), -1, '0});
    rows.push_back('{reading(3'd1, -16'sd1), -1, '0});
    // Disabling a zone silences its readings.
    rows.push_back('{zone_wr(3'd0, 8'h5A, 1'b0, 4'd0), 0, '0});
    rows.push_back('{reading(3'd0, 16'sd0), 0, '0});
    // Last zone and last trip slot, other-kind trip sets and clears.
    rows.push_back('{trip_wr(3'd7, 3'd7, 16'sd0, 15'd0, ttm_pkg::KIND_OTHER), 0, '0});
    rows.push_back('{zone_wr(3'd7, 8'h00, 1'b1, 4'd8), 0, '0});
    rows.push_back('{reading(3'd7, 16'sd0), -1, '0});
    rows.push_back('{reading(3'd7, -16'sd1), -1, '0});

    foreach (rows[r]) send_item(rows[r].item, rows[r].want_count, rows[r].want);

    // Random part: mostly writes and readings around small thresholds.
    useful = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin in_idle_pct = 16; out_stall_pct = 64; end
        1:       begin in_idle_pct = 64; out_stall_pct = 16; end
        default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      endcase
      while (useful < (phase + 1) * RANDOM_ITEMS / 3) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          it = zone_wr(3'($urandom_range(7)), 8'($urandom), ($urandom_range(99) < 85),
                       4'($urandom_range(15)));
        end else if (pick < 32) begin
          it = trip_wr(3'($urandom_range(7)), 3'($urandom_range(7)), 16'sd0, 15'd0,
                       2'($urandom_range(3)));
          if ($urandom_range(99) < 85) begin
            tv = int'($urandom_range(400)) - 200;
            it.threshold = 16'(tv);
          end
          if ($urandom_range(99) < 80) it.hysteresis = 15'($urandom_range(100));
        end else if (pick < 95) begin
          it = reading(3'($urandom_range(7)), 16'sd0);
          tv = $urandom_range(99);
          if (tv < 5) begin
            it.temperature = ttm_pkg::NO_READING;
          end else if (tv < 85) begin
            tv = int'($urandom_range(800)) - 400;
            it.temperature = 16'(tv);
          end
        end else begin
          it = noise_item();
          it.cmd = CMD_UNUSED;
        end
        send_item(it, -1, '0);
        if (it.cmd != CMD_UNUSED) useful++;
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding events, then give the block time to show any extras.
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d items transferred, %0d events checked, %0d mismatches",
             items_sent, events_seen, errors);
    $display("summary: directed extremes plus random traffic under three stall mixes");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
